@@ rtl/ddsp_pkg.sv @@
// ddsp_pkg: widths, configuration register codes and shared types for the
// differential-drive speed to PWM pipeline. Depends on nothing.
`default_nettype none

package ddsp_pkg;

    localparam int SPEED_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int GAIN_W      = 20;
    localparam int MAG_W       = 20;
    localparam int DUTY_W      = 8;

    // |w| < 0.6 m/s in Q8.8 is 5*|w| < 768, i.e. |w| < 154
    localparam logic [SPEED_W:0] KNEE_LIMIT = 17'd154;

    // floor(n/3) = (n * DIV3_MUL) >> DIV3_SHIFT, exact for n < 2^21
    localparam logic [20:0] DIV3_MUL   = 21'd1398102;
    localparam int          DIV3_SHIFT = 22;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SEMI_BASE       = 3'd0,
        REG_CURVE_SLOPE     = 3'd1,
        REG_CURVE_INTERCEPT = 3'd2,
        REG_MIN_PWM         = 3'd3,
        REG_MAX_PWM         = 3'd4,
        REG_DEAD_PWM        = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic        [15:0]       slope;
        logic signed [15:0]       icpt;
        logic signed [GAIN_W-1:0] gain;   // 3*slope + 5*icpt
    } curve_cfg_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } pwm_part_t;

    function automatic logic signed [SPEED_W-1:0] sat_speed(input logic signed [25:0] v);
        logic signed [SPEED_W-1:0] r;
        if (v > 26'sd32767)
            r = 16'sh7fff;
        else if (v < -26'sd32768)
            r = 16'sh8000;
        else
            r = v[SPEED_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ddsp_pwm_map.sv @@
// ddsp_pwm_map: three-stage map of one wheel speed onto the motor curve,
// giving sign and unsaturated magnitude of the PWM count. Uses ddsp_pkg.
`default_nettype none

module ddsp_pwm_map
    import ddsp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      advance,
    input  wire logic signed [SPEED_W-1:0] speed,
    input  wire curve_cfg_t                curve,
    output pwm_part_t                      part
);

    // stage A: knee test and both products
    logic        [SPEED_W:0]  abs_speed;
    logic                     knee_next;
    logic signed [35:0]       lo_next;
    logic        [32:0]       hi_next;

    logic                     knee_a_reg;
    logic                     wneg_a_reg;
    logic signed [35:0]       lo_a_reg;
    logic        [32:0]       hi_a_reg;

    // stage B: magnitudes
    logic signed [33:0]       x_above;
    logic        [33:0]       abs_above;
    logic        [35:0]       abs_below;
    logic        [MAG_W-1:0]  mag_next;
    logic                     neg_next;

    logic                     knee_b_reg;
    logic                     neg_b_reg;
    logic        [MAG_W-1:0]  mag_b_reg;

    // stage C: divide by three below the knee
    logic        [40:0]       div_prod;
    logic        [MAG_W-1:0]  q_next;
    pwm_part_t                part_reg;

    assign abs_speed = speed[SPEED_W-1] ? (SPEED_W+1)'(-{speed[SPEED_W-1], speed})
                                        : {1'b0, speed};
    assign knee_next = abs_speed < KNEE_LIMIT;
    assign lo_next   = $signed(curve.gain) * speed;
    assign hi_next   = abs_speed * curve.slope;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            knee_a_reg <= knee_next;
            wneg_a_reg <= speed[SPEED_W-1];
            lo_a_reg   <= lo_next;
            hi_a_reg   <= hi_next;
        end
    end

    assign x_above   = $signed({1'b0, hi_a_reg})
                     + $signed({{10{curve.icpt[15]}}, curve.icpt, 8'd0});
    assign abs_above = x_above[33] ? 34'(-x_above) : x_above;
    assign abs_below = lo_a_reg[35] ? 36'(-lo_a_reg) : lo_a_reg;

    always_comb
    begin
        if (knee_a_reg)
        begin
            mag_next = abs_below[35:16];
            neg_next = lo_a_reg[35];
        end
        else
        begin
            mag_next = {2'b00, abs_above[33:16]};
            neg_next = x_above[33] ^ wneg_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            knee_b_reg <= knee_a_reg;
            neg_b_reg  <= neg_next;
            mag_b_reg  <= mag_next;
        end
    end

    assign div_prod = mag_b_reg * DIV3_MUL;
    assign q_next   = knee_b_reg ? {1'b0, div_prod[40:DIV3_SHIFT]} : mag_b_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            part_reg.neg <= neg_b_reg;
            part_reg.mag <= q_next;
        end
    end

    assign part = part_reg;

endmodule

`default_nettype wire

@@ rtl/diff_drive_speed_to_pwm_unit.sv @@
// diff_drive_speed_to_pwm_unit: setpoint to wheel speeds, PWM counts and duties.
// Uses ddsp_pkg and two ddsp_pwm_map instances. One setpoint per cycle sustained
// while result_stall is low; the six-stage pipeline (product, wheel sum, curve
// products, magnitude, divide, clamp) sets it.
// Reset clears valid bits and loads register defaults (max_pwm 255, rest 0).
`default_nettype none

module diff_drive_speed_to_pwm_unit
    import ddsp_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          setpoint_valid,
    output logic                               setpoint_stall,
    input  wire logic signed [SPEED_W-1:0]     linear_speed,
    input  wire logic signed [SPEED_W-1:0]     angular_speed,

    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic signed [SPEED_W-1:0]          left_speed,
    output logic signed [SPEED_W-1:0]          right_speed,
    output logic signed [SPEED_W-1:0]          left_signed_pwm,
    output logic signed [SPEED_W-1:0]          right_signed_pwm,
    output logic                               left_dir,
    output logic                               right_dir,
    output logic        [DUTY_W-1:0]           left_duty,
    output logic        [DUTY_W-1:0]           right_duty,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; unknown indexes
    // are dropped. The knee gain 3*slope + 5*intercept is kept registered
    // so the curve multipliers see a settled operand.
    // ------------------------------------------------------------------
    logic        [15:0]       semi_base_reg;
    logic        [15:0]       curve_slope_reg;
    logic signed [15:0]       curve_icpt_reg;
    logic        [DUTY_W-1:0] min_pwm_reg;
    logic        [DUTY_W-1:0] max_pwm_reg;
    logic        [DUTY_W-1:0] dead_pwm_reg;
    logic signed [GAIN_W-1:0] gain_reg;
    logic signed [GAIN_W-1:0] gain_next;
    curve_cfg_t               curve;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            semi_base_reg   <= '0;
            curve_slope_reg <= '0;
            curve_icpt_reg  <= '0;
            min_pwm_reg     <= '0;
            max_pwm_reg     <= '1;
            dead_pwm_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SEMI_BASE:       semi_base_reg   <= cfg_data;
                REG_CURVE_SLOPE:     curve_slope_reg <= cfg_data;
                REG_CURVE_INTERCEPT: curve_icpt_reg  <= cfg_data;
                REG_MIN_PWM:         min_pwm_reg     <= cfg_data[DUTY_W-1:0];
                REG_MAX_PWM:         max_pwm_reg     <= cfg_data[DUTY_W-1:0];
                REG_DEAD_PWM:        dead_pwm_reg    <= cfg_data[DUTY_W-1:0];
                default:             ;
            endcase
        end
    end

    // slope + 2*slope + 4*intercept + intercept
    assign gain_next = $signed({4'd0, curve_slope_reg})
                     + $signed({3'd0, curve_slope_reg, 1'b0})
                     + $signed({{2{curve_icpt_reg[15]}}, curve_icpt_reg, 2'b00})
                     + $signed({{4{curve_icpt_reg[15]}}, curve_icpt_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= '0;
        else
            gain_reg <= gain_next;
    end

    assign curve = {curve_slope_reg, curve_icpt_reg, gain_reg};

    // ------------------------------------------------------------------
    // Pipeline control: the whole pipe moves together; hold everything
    // while a finished word sits at the output and the sink stalls.
    // ------------------------------------------------------------------
    logic       advance;
    logic [5:0] valid_reg;

    assign advance        = !valid_reg[5] || !result_stall;
    assign setpoint_stall = !advance;
    assign result_valid   = valid_reg[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[4:0], setpoint_valid};
    end

    // ------------------------------------------------------------------
    // Stage 1: semi_base * angular speed (Q16.16, exact).
    // ------------------------------------------------------------------
    logic signed [32:0]        turn_reg;
    logic signed [SPEED_W-1:0] lin_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            turn_reg <= $signed({1'b0, semi_base_reg}) * angular_speed;
            lin_reg  <= linear_speed;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: wheel speeds. Floor to Q8.8 is an arithmetic shift, then
    // saturate to 16 bits.
    // ------------------------------------------------------------------
    logic signed [33:0]        lin_scaled;
    logic signed [33:0]        left_sum;
    logic signed [33:0]        right_sum;
    logic signed [SPEED_W-1:0] wl_s2_reg;
    logic signed [SPEED_W-1:0] wr_s2_reg;

    assign lin_scaled = $signed({{10{lin_reg[15]}}, lin_reg, 8'd0});
    assign left_sum   = lin_scaled - 34'(turn_reg);
    assign right_sum  = lin_scaled + 34'(turn_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            wl_s2_reg <= sat_speed(left_sum[33:8]);
            wr_s2_reg <= sat_speed(right_sum[33:8]);
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 to 5: motor curve per wheel. Carry the wheel speeds along.
    // ------------------------------------------------------------------
    pwm_part_t                 left_part;
    pwm_part_t                 right_part;
    logic signed [SPEED_W-1:0] wl_s3_reg, wl_s4_reg, wl_s5_reg;
    logic signed [SPEED_W-1:0] wr_s3_reg, wr_s4_reg, wr_s5_reg;

    ddsp_pwm_map u_left_map
    (
        .clk     (clk),
        .advance (advance),
        .speed   (wl_s2_reg),
        .curve   (curve),
        .part    (left_part)
    );

    ddsp_pwm_map u_right_map
    (
        .clk     (clk),
        .advance (advance),
        .speed   (wr_s2_reg),
        .curve   (curve),
        .part    (right_part)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            wl_s3_reg <= wl_s2_reg;
            wl_s4_reg <= wl_s3_reg;
            wl_s5_reg <= wl_s4_reg;
            wr_s3_reg <= wr_s2_reg;
            wr_s4_reg <= wr_s3_reg;
            wr_s5_reg <= wr_s4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: saturate the signed count, split direction and magnitude,
    // clamp to [min_pwm, max_pwm] (min wins), then the common deadband.
    // A zero count is non-positive: left_dir 1, right_dir 0.
    // ------------------------------------------------------------------
    logic        [15:0]        left_mag;
    logic        [15:0]        right_mag;
    logic signed [SPEED_W-1:0] left_pwm_next;
    logic signed [SPEED_W-1:0] right_pwm_next;
    logic        [DUTY_W-1:0]  left_clamp;
    logic        [DUTY_W-1:0]  right_clamp;
    logic        [DUTY_W-1:0]  left_duty_next;
    logic        [DUTY_W-1:0]  right_duty_next;
    logic                      left_pos;
    logic                      right_pos;

    always_comb
    begin
        if (left_part.neg)
            left_mag = (left_part.mag > 20'd32768) ? 16'd32768 : left_part.mag[15:0];
        else
            left_mag = (left_part.mag > 20'd32767) ? 16'd32767 : left_part.mag[15:0];

        if (right_part.neg)
            right_mag = (right_part.mag > 20'd32768) ? 16'd32768 : right_part.mag[15:0];
        else
            right_mag = (right_part.mag > 20'd32767) ? 16'd32767 : right_part.mag[15:0];

        left_pwm_next  = left_part.neg  ? $signed(16'(~left_mag + 16'd1))  : $signed(left_mag);
        right_pwm_next = right_part.neg ? $signed(16'(~right_mag + 16'd1)) : $signed(right_mag);
        left_pos       = !left_part.neg  && (left_mag != 16'd0);
        right_pos      = !right_part.neg && (right_mag != 16'd0);

        priority if (left_mag < {8'd0, min_pwm_reg})
            left_clamp = min_pwm_reg;
        else if (left_mag > {8'd0, max_pwm_reg})
            left_clamp = max_pwm_reg;
        else
            left_clamp = left_mag[DUTY_W-1:0];

        priority if (right_mag < {8'd0, min_pwm_reg})
            right_clamp = min_pwm_reg;
        else if (right_mag > {8'd0, max_pwm_reg})
            right_clamp = max_pwm_reg;
        else
            right_clamp = right_mag[DUTY_W-1:0];

        if ((left_clamp < dead_pwm_reg) && (right_clamp < dead_pwm_reg))
        begin
            left_duty_next  = '0;
            right_duty_next = '0;
        end
        else
        begin
            left_duty_next  = left_clamp;
            right_duty_next = right_clamp;
        end
    end

    logic signed [SPEED_W-1:0] left_speed_reg;
    logic signed [SPEED_W-1:0] right_speed_reg;
    logic signed [SPEED_W-1:0] left_pwm_reg;
    logic signed [SPEED_W-1:0] right_pwm_reg;
    logic                      left_dir_reg;
    logic                      right_dir_reg;
    logic        [DUTY_W-1:0]  left_duty_reg;
    logic        [DUTY_W-1:0]  right_duty_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_speed_reg  <= wl_s5_reg;
            right_speed_reg <= wr_s5_reg;
            left_pwm_reg    <= left_pwm_next;
            right_pwm_reg   <= right_pwm_next;
            left_dir_reg    <= !left_pos;
            right_dir_reg   <= right_pos;
            left_duty_reg   <= left_duty_next;
            right_duty_reg  <= right_duty_next;
        end
    end

    assign left_speed       = left_speed_reg;
    assign right_speed      = right_speed_reg;
    assign left_signed_pwm  = left_pwm_reg;
    assign right_signed_pwm = right_pwm_reg;
    assign left_dir         = left_dir_reg;
    assign right_dir        = right_dir_reg;
    assign left_duty        = left_duty_reg;
    assign right_duty       = right_duty_reg;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for diff_drive_speed_to_pwm_unit.
// Drives setpoints and register writes, predicts every result word in SystemVerilog
// and compares it field by field. Depends on ddsp_pkg and the unit's RTL only.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ddsp_pkg::*;

    // Indexes past the end of the register list: writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    // Six-stage pipeline; settle a little beyond that before touching registers
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 135;
    localparam int MAX_REPORTS    = 200;

    // One result word, as the unit presents it
    typedef struct packed {
        logic [15:0] left_speed;
        logic [15:0] right_speed;
        logic [15:0] left_pwm;
        logic [15:0] right_pwm;
        logic        left_dir;
        logic        right_dir;
        logic [7:0]  left_duty;
        logic [7:0]  right_duty;
    } drive_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      setpoint_valid = 1'b0;
    logic                      setpoint_stall;
    logic signed [SPEED_W-1:0] linear_speed = '0;
    logic signed [SPEED_W-1:0] angular_speed = '0;

    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic signed [SPEED_W-1:0] left_speed;
    logic signed [SPEED_W-1:0] right_speed;
    logic signed [SPEED_W-1:0] left_signed_pwm;
    logic signed [SPEED_W-1:0] right_signed_pwm;
    logic                      left_dir;
    logic                      right_dir;
    logic [DUTY_W-1:0]         left_duty;
    logic [DUTY_W-1:0]         right_duty;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    // Shadow copy of the unit's registers, reset values included
    logic [15:0]        sh_semi_base = 16'd0;
    logic [15:0]        sh_slope     = 16'd0;
    logic signed [15:0] sh_icpt      = 16'sd0;
    logic [7:0]         sh_min_pwm   = 8'd0;
    logic [7:0]         sh_max_pwm   = 8'd255;
    logic [7:0]         sh_dead_pwm  = 8'd0;

    // Result words still owed by the unit, oldest first
    drive_word_t pending_drive[$];

    int  mismatch_count = 0;
    int  setpoints_sent = 0;
    int  words_checked  = 0;
    int  settings_used  = 0;
    bit  send_gaps      = 1'b1;
    bit  stall_gaps     = 1'b1;

    diff_drive_speed_to_pwm_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .setpoint_valid   (setpoint_valid),
        .setpoint_stall   (setpoint_stall),
        .linear_speed     (linear_speed),
        .angular_speed    (angular_speed),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .left_speed       (left_speed),
        .right_speed      (right_speed),
        .left_signed_pwm  (left_signed_pwm),
        .right_signed_pwm (right_signed_pwm),
        .left_dir         (left_dir),
        .right_dir        (right_dir),
        .left_duty        (left_duty),
        .right_duty       (right_duty),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic longint sat16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Exact Q16.16 sum, floored to Q8.8 by the arithmetic shift, then saturated
    function automatic longint wheel_speed_of(input longint lin, input longint ang,
                                              input longint side);
        longint acc;
        acc = lin * 256 + side * longint'(sh_semi_base) * ang;
        return sat16(acc >>> 8);
    endfunction

    // Two-piece motor curve; the knee at 0.6 m/s is tested exactly as 5*|w| < 768
    function automatic longint curve_pwm_of(input longint w);
        longint aw;
        longint slope;
        longint icpt;
        longint t;
        aw    = (w < 0) ? -w : w;
        slope = longint'(sh_slope);
        icpt  = longint'(sh_icpt);
        if (aw * 5 < 768)
            return sat16(((3 * slope + 5 * icpt) * w) / 196608);
        t = (aw * slope + 256 * icpt) / 65536;
        if (w < 0)
            t = -t;
        return sat16(t);
    endfunction

    // Lower clamp wins when min_pwm exceeds max_pwm
    function automatic longint clamp_duty(input longint m);
        if (m < longint'(sh_min_pwm))
            return longint'(sh_min_pwm);
        if (m > longint'(sh_max_pwm))
            return longint'(sh_max_pwm);
        return m;
    endfunction

    function automatic drive_word_t predict_drive(input logic signed [15:0] lin,
                                                  input logic signed [15:0] ang);
        drive_word_t r;
        longint wl;
        longint wr;
        longint pl;
        longint pr;
        longint ml;
        longint mr;
        wl = wheel_speed_of(lin, ang, -1);
        wr = wheel_speed_of(lin, ang, 1);
        pl = curve_pwm_of(wl);
        pr = curve_pwm_of(wr);
        // zero counts as non-positive; left motor is mirrored
        r.left_dir  = (pl > 0) ? 1'b0 : 1'b1;
        r.right_dir = (pr > 0) ? 1'b1 : 1'b0;
        ml = clamp_duty((pl > 0) ? pl : -pl);
        mr = clamp_duty((pr > 0) ? pr : -pr);
        if (ml < longint'(sh_dead_pwm) && mr < longint'(sh_dead_pwm))
        begin
            ml = 0;
            mr = 0;
        end
        r.left_speed  = wl[15:0];
        r.right_speed = wr[15:0];
        r.left_pwm    = pl[15:0];
        r.right_pwm   = pr[15:0];
        r.left_duty   = ml[7:0];
        r.right_duty  = mr[7:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall and the checker
    // ------------------------------------------------------------------

    always @(posedge clk)
        result_stall <= stall_gaps && ($urandom_range(0, 99) < 6);

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            if (mismatch_count < MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, $signed(want), $signed(got));
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        drive_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_drive.size() == 0)
            begin
                $display("%0t ns: result word with nothing outstanding, expected none, actual %h",
                         $time, {left_speed, right_speed});
                mismatch_count++;
            end
            else
            begin
                want = pending_drive.pop_front();
                check_field("left_speed",       want.left_speed,  left_speed);
                check_field("right_speed",      want.right_speed, right_speed);
                check_field("left_signed_pwm",  want.left_pwm,    left_signed_pwm);
                check_field("right_signed_pwm", want.right_pwm,   right_signed_pwm);
                check_field("left_dir",         {15'd0, want.left_dir},  {15'd0, left_dir});
                check_field("right_dir",        {15'd0, want.right_dir}, {15'd0, right_dir});
                check_field("left_duty",        {8'd0, want.left_duty},  {8'd0, left_duty});
                check_field("right_duty",       {8'd0, want.right_duty}, {8'd0, right_duty});
                words_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Offer one setpoint; hold the word until the unit takes it. Valid stays high
    // afterwards so that back-to-back words go out on consecutive cycles.
    task automatic send_setpoint(input logic signed [15:0] lin,
                                 input logic signed [15:0] ang);
        while (send_gaps && $urandom_range(0, 99) < 6)
        begin
            setpoint_valid <= 1'b0;
            @(posedge clk);
        end
        setpoint_valid <= 1'b1;
        linear_speed   <= lin;
        angular_speed  <= ang;
        @(posedge clk);
        while (setpoint_stall)
            @(posedge clk);
        pending_drive.push_back(predict_drive(lin, ang));
        setpoints_sent++;
    endtask

    // Drop valid, wait for every owed word, then let the pipeline empty fully
    task automatic settle_pipeline();
        setpoint_valid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Drop valid for one cycle after each write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SEMI_BASE:       sh_semi_base = data;
            REG_CURVE_SLOPE:     sh_slope     = data;
            REG_CURVE_INTERCEPT: sh_icpt      = data;
            REG_MIN_PWM:         sh_min_pwm   = data[7:0];
            REG_MAX_PWM:         sh_max_pwm   = data[7:0];
            REG_DEAD_PWM:        sh_dead_pwm  = data[7:0];
            default:             ;
        endcase
        @(posedge clk);
    endtask

    // Only ever called with the pipeline empty. The 8-bit registers get junk in
    // the upper byte, which the unit must drop.
    task automatic load_config(input logic [15:0] semi, input logic [15:0] slope,
                               input logic [15:0] icpt, input logic [7:0] min_pwm,
                               input logic [7:0] max_pwm, input logic [7:0] dead_pwm);
        settle_pipeline();
        write_reg(REG_SEMI_BASE,       semi);
        write_reg(REG_CURVE_SLOPE,     slope);
        write_reg(REG_CURVE_INTERCEPT, icpt);
        write_reg(REG_MIN_PWM,  {8'($urandom_range(0, 255)), min_pwm});
        write_reg(REG_MAX_PWM,  {8'($urandom_range(0, 255)), max_pwm});
        write_reg(REG_DEAD_PWM, {8'($urandom_range(0, 255)), dead_pwm});
        settings_used++;
    endtask

    function automatic logic signed [15:0] rand_word();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic signed [15:0] rand_around(input int span);
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'sh0001;
            default: return 16'shffff;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers untouched: zero slope and intercept give zero PWM everywhere
    task automatic test_reset_defaults();
        send_setpoint(16'sh0000, 16'sh0000);
        send_setpoint(16'sh7fff, 16'sh8000);
        send_setpoint(16'sh8000, 16'sh7fff);
    endtask

    // Widest half base drives both wheel sums into saturation; odd negative
    // sums check the floor towards minus infinity
    task automatic test_wheel_saturation();
        load_config(16'hffff, 16'd51200, 16'd7680, 8'd0, 8'd255, 8'd0);
        send_setpoint(16'sh7fff, 16'sh7fff);
        send_setpoint(16'sh8000, 16'sh8000);
        send_setpoint(16'sh0001, 16'sh0001);
        send_setpoint(16'sh0000, 16'shffff);
    endtask

    // Either side of the knee, zero PWM, signed PWM saturation and a negative
    // intercept that turns a forward speed into a reverse count
    task automatic test_motor_curve();
        load_config(16'd0, 16'd51200, 16'd7680, 8'd0, 8'd255, 8'd0);
        send_setpoint(16'sd153, 16'sd0);
        send_setpoint(16'sd154, 16'sd0);
        send_setpoint(-16'sd153, 16'sd0);
        send_setpoint(-16'sd154, 16'sd0);
        send_setpoint(16'sd0, 16'sd0);
        send_setpoint(16'sd1, 16'sd0);
        load_config(16'd0, 16'hffff, 16'h7fff, 8'd0, 8'd255, 8'd0);
        send_setpoint(16'sh7fff, 16'sd0);
        send_setpoint(16'sh8000, 16'sd0);
        load_config(16'd0, 16'd0, 16'h8000, 8'd0, 8'd255, 8'd0);
        send_setpoint(16'sd154, 16'sd0);
        send_setpoint(16'sd153, 16'sd0);
        send_setpoint(-16'sd154, 16'sd0);
    endtask

    // min above max, then a deadband with both wheels below it or only one
    task automatic test_clamp_and_deadband();
        load_config(16'd0, 16'd51200, 16'd0, 8'd100, 8'd50, 8'd0);
        send_setpoint(16'sd13, 16'sd0);
        send_setpoint(16'sd96, 16'sd0);
        send_setpoint(-16'sd256, 16'sd0);
        load_config(16'd256, 16'd51200, 16'd0, 8'd20, 8'd255, 8'd60);
        send_setpoint(16'sd40, 16'sd0);
        send_setpoint(16'sd40, 16'sd60);
        send_setpoint(16'sd0, 16'sd0);
    endtask

    // Writes past the register list must leave every setting as it was
    task automatic test_spare_registers();
        load_config(16'd26, 16'd51200, 16'd7680, 8'd40, 8'd230, 8'd45);
        write_reg(REG_SPARE_LO, 16'hffff);
        write_reg(REG_SPARE_HI, 16'hffff);
        send_setpoint(16'sd300, 16'sd200);
        send_setpoint(-16'sd300, -16'sd50);
    endtask

    // Phases of random setpoints, each under its own register setting. The first
    // two settings are the extremes; two phases in the middle run without gaps.
    task automatic test_random_traffic();
        logic signed [15:0] lin;
        logic signed [15:0] ang;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                load_config(16'hffff, 16'hffff, 16'h7fff, 8'd255, 8'd255, 8'd255);
            else if (phase == 1)
                load_config(16'd0, 16'd0, 16'h8000, 8'd0, 8'd0, 8'd0);
            else
                load_config($urandom_range(0, 1) ? 16'($urandom_range(0, 512)) : rand_word(),
                            rand_word(), rand_word(),
                            8'($urandom_range(0, 80)),
                            $urandom_range(0, 3) ? 8'($urandom_range(150, 255))
                                                 : 8'($urandom_range(0, 255)),
                            $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 120)));
            send_gaps  = !(phase == 4 || phase == 5);
            stall_gaps = send_gaps;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        lin = rand_word();
                        ang = rand_word();
                    end
                    4, 5, 6:
                    begin
                        lin = rand_around(400);
                        ang = rand_around(400);
                    end
                    7:
                    begin
                        // straddle the knee
                        lin = 16'($urandom_range(150, 158));
                        if ($urandom_range(0, 1))
                            lin = -lin;
                        ang = rand_around(2);
                    end
                    8:
                    begin
                        lin = pick_extreme();
                        ang = pick_extreme();
                    end
                    default:
                    begin
                        lin = rand_word();
                        ang = 16'sd0;
                    end
                endcase
                send_setpoint(lin, ang);
            end
        end
        send_gaps  = 1'b1;
        stall_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        // hold reset, then release it on a rising edge
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_wheel_saturation();
        test_motor_curve();
        test_clamp_and_deadband();
        test_spare_registers();
        test_random_traffic();

        settle_pipeline();
        if (pending_drive.size() != 0)
        begin
            $display("%0t ns: %0d result words never arrived, expected 0, actual %0d",
                     $time, pending_drive.size(), pending_drive.size());
            mismatch_count++;
        end

        $display("Sent %0d setpoints across %0d register settings; %0d result words checked.",
                 setpoints_sent, settings_used, words_checked);
        $display("Field mismatches seen: %0d.", mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: fail the run if it has not finished by the timeout below
    initial
    begin
        #(12 * 200000);
        $display("Timeout waiting for the unit");
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ddsp_pkg.sv
rtl/ddsp_pwm_map.sv
rtl/diff_drive_speed_to_pwm_unit.sv
tb/tb_top.sv
